// ===== design/atm_strike_watch_interpolator_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ATM_STRIKE_WATCH_INTERPOLATOR_MACROS_SVH
`define ATM_STRIKE_WATCH_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASWI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aswi check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASWI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aswi check failed");

`endif

// ===== design/aswi_pkg.sv =====
package aswi_pkg;

  localparam int PRICE_W = 32;
  localparam int VOL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = 6;
  localparam int COUNT_W = 7;
  localparam int PROD_W  = PRICE_W + VOL_W;

  // Input actions.
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // Result kinds.
  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_STOP  = 2'd1,
    EV_VOL   = 2'd2
  } event_e;

  // Result word being presented.
  typedef enum logic [2:0] {
    EM_START_U,
    EM_START_M,
    EM_START_L,
    EM_STOP_U,
    EM_STOP_M,
    EM_STOP_L,
    EM_VOL
  } emit_e;

  // Read address source for the table memories.
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_L,
    RD_M,
    RD_U
  } rdsel_e;

  // Capture target for read data.
  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_L,
    CAP_M,
    CAP_U
  } cap_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FETCH_L,
    ST_FETCH_M,
    ST_FETCH_U,
    ST_FETCH_END,
    ST_INT_A,
    ST_INT_B,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SAT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic   take;
    logic   clr_step;
    logic   scan_clr;
    logic   scan_step;
    logic   commit_up;
    logic   commit_dn;
    rdsel_e rd_sel;
    cap_e   cap;
    logic   int_a;
    logic   trig_ld;
    logic   int_b;
    logic   div_go;
    logic   sat;
    emit_e  emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic outside;
    logic k_end;
    logic hit;
    logic k_zero;
    logic upper_side;
    logic upper_ok;
    logic lower_ok;
    logic direct;
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== design/aswi_if.sv =====
// Input word channel.
interface aswi_in_if import aswi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [ENTRY_W-1:0] entry_index;
  logic [PRICE_W-1:0] strike_price;
  logic [VOL_W-1:0]   call_vol_in;
  logic [VOL_W-1:0]   put_vol_in;
  logic [PRICE_W-1:0] underlying_price;
  logic [TIME_W-1:0]  tick_time;

  modport source (output valid, action, entry_index, strike_price, call_vol_in, put_vol_in,
                  underlying_price, tick_time, input ready);
  modport sink (input valid, action, entry_index, strike_price, call_vol_in, put_vol_in,
                underlying_price, tick_time, output ready);
endinterface

// Result word channel.
interface aswi_out_if import aswi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [ENTRY_W-1:0] watched_entry;
  logic [TIME_W-1:0]  out_time;
  logic [PRICE_W-1:0] out_price;
  logic [VOL_W-1:0]   call_vol_out;
  logic [VOL_W-1:0]   put_vol_out;
  logic               last;

  modport source (output valid, event_kind, watched_entry, out_time, out_price,
                  call_vol_out, put_vol_out, last, input ready);
  modport sink (input valid, event_kind, watched_entry, out_time, out_price,
                call_vol_out, put_vol_out, last, output ready);
endinterface

// Strike count write channel.
interface aswi_cfg_if import aswi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] strike_count;

  modport source (output valid, strike_count, input ready);
  modport sink (input valid, strike_count, output ready);
endinterface

// ===== design/aswi_div.sv =====
module aswi_div import aswi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [PROD_W-1:0]  dividend_i,
  input  logic [PRICE_W-1:0] divisor_i,
  output logic [PROD_W-1:0]  quotient_o,
  output logic               busy_o
);

  localparam int CNT_W = $clog2(PROD_W);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  dd_q;
  logic [PRICE_W-1:0] rem_q;
  logic [PRICE_W-1:0] div_q;
  logic [PRICE_W:0]   trial_w;
  logic               fit_w;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign trial_w = {rem_q, dd_q[PROD_W-1]};
  assign fit_w   = trial_w >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(PROD_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dd_q  <= {dd_q[PROD_W-2:0], fit_w};
      rem_q <= fit_w ? PRICE_W'(trial_w - {1'b0, div_q}) : trial_w[PRICE_W-1:0];
    end
  end

  assign quotient_o = dd_q;
  assign busy_o     = busy_q;

endmodule

// ===== design/aswi_dp.sv =====
module aswi_dp import aswi_pkg::*; #(
  parameter int MAX_STRIKES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  input  logic [1:0]         action_i,
  input  logic [ENTRY_W-1:0] entry_index_i,
  input  logic [PRICE_W-1:0] strike_price_i,
  input  logic [VOL_W-1:0]   call_vol_in_i,
  input  logic [VOL_W-1:0]   put_vol_in_i,
  input  logic [PRICE_W-1:0] underlying_price_i,
  input  logic [TIME_W-1:0]  tick_time_i,
  input  logic               cfg_valid_i,
  input  logic [COUNT_W-1:0] strike_count_i,
  output logic [1:0]         event_kind_o,
  output logic [ENTRY_W-1:0] watched_entry_o,
  output logic [TIME_W-1:0]  out_time_o,
  output logic [PRICE_W-1:0] out_price_o,
  output logic [VOL_W-1:0]   call_vol_out_o,
  output logic [VOL_W-1:0]   put_vol_out_o
);

  localparam int AW = (MAX_STRIKES > 1) ? $clog2(MAX_STRIKES) : 1;
  localparam int CW = $clog2(MAX_STRIKES + 1);

  // Adds the signed quotient to the base volatility and clamps to the unsigned range.
  function automatic logic [VOL_W-1:0] apply_quot(input logic [VOL_W-1:0] va,
                                                  input logic [PROD_W-1:0] q,
                                                  input logic neg, input logic direct);
    logic [PROD_W+2:0] qx;
    logic [PROD_W+2:0] vs;
    qx = direct ? '0 : {3'b000, q};
    if (neg) begin
      qx = (PROD_W + 3)'(0) - qx;
    end
    vs = {{(PROD_W + 3 - VOL_W){1'b0}}, va} + qx;
    if (vs[PROD_W+2]) begin
      return '0;
    end else if (|vs[PROD_W+1:VOL_W]) begin
      return '1;
    end
    return vs[VOL_W-1:0];
  endfunction

  logic [COUNT_W-1:0] cnt_q;
  logic [CW-1:0]      n_w;
  logic [PRICE_W-1:0] smem [MAX_STRIKES];
  logic [VOL_W-1:0]   cmem [MAX_STRIKES];
  logic [VOL_W-1:0]   pmem [MAX_STRIKES];
  logic               entry_ok_w;
  logic [AW-1:0]      waddr_w;
  logic [AW-1:0]      raddr_w;
  logic [AW-1:0]      clr_q;
  logic               vwe_w;
  logic [AW-1:0]      vaddr_w;
  logic [VOL_W-1:0]   vdc_w;
  logic [VOL_W-1:0]   vdp_w;
  logic [PRICE_W-1:0] rs_q;
  logic [VOL_W-1:0]   rc_q;
  logic [VOL_W-1:0]   rp_q;
  logic [PRICE_W-1:0] price_q;
  logic [TIME_W-1:0]  time_q;
  logic [AW-1:0]      l_q, m_q, u_q;
  logic [AW-1:0]      ol_q, om_q, ou_q;
  logic [CW-1:0]      k_q;
  logic [AW-1:0]      ki_w;
  logic [PRICE_W-1:0] prev_q;
  logic [PRICE_W-1:0] sl_q, sm_q, su_q;
  logic [VOL_W-1:0]   cl_q, cm_q, cu_q;
  logic [VOL_W-1:0]   pl_q, pm_q, pu_q;
  logic [PRICE_W-1:0] ut_q, lt_q;
  logic               above_w, eq_w;
  logic [PRICE_W-1:0] sa_w, sb_w;
  logic [VOL_W-1:0]   vac_w, vbc_w, vap_w, vbp_w;
  logic [PRICE_W:0]   den_w, dp_w, den_n_w, dp_n_w;
  logic [VOL_W:0]     dvc_w, dvp_w, dvc_n_w, dvp_n_w;
  logic [PRICE_W-1:0] den_mag_q, dp_mag_q;
  logic [VOL_W-1:0]   dvc_mag_q, dvp_mag_q;
  logic               negc_q, negp_q, direct_q;
  logic [VOL_W-1:0]   vac_q, vap_q;
  logic [PROD_W-1:0]  prodc_q, prodp_q;
  logic [PROD_W-1:0]  qc_w, qp_w;
  logic               busy_c_w, busy_p_w;
  logic [VOL_W-1:0]   cv_q, pv_q;

  // Strike count register and its clamp to the table depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_valid_i) begin
      cnt_q <= strike_count_i;
    end
  end

  assign n_w = (32'(cnt_q) > 32'(MAX_STRIKES)) ? CW'(MAX_STRIKES) : CW'(cnt_q);

  // Table writes: loads, volatility updates and the clearing pass after reset.
  assign entry_ok_w = 32'(entry_index_i) < 32'(MAX_STRIKES);
  assign waddr_w    = AW'(entry_index_i);
  assign vwe_w      = cmd_i.clr_step ||
                      (cmd_i.take && action_i == ACT_UPDATE && entry_ok_w);
  assign vaddr_w    = cmd_i.clr_step ? clr_q : waddr_w;
  assign vdc_w      = cmd_i.clr_step ? '0 : call_vol_in_i;
  assign vdp_w      = cmd_i.clr_step ? '0 : put_vol_in_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && action_i == ACT_LOAD && entry_ok_w) begin
      smem[waddr_w] <= strike_price_i;
    end
    if (vwe_w) begin
      cmem[vaddr_w] <= vdc_w;
      pmem[vaddr_w] <= vdp_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // Shared registered read port.
  assign ki_w = k_q[AW-1:0];

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SCAN: raddr_w = ki_w;
      RD_L:    raddr_w = l_q;
      RD_M:    raddr_w = m_q;
      RD_U:    raddr_w = u_q;
      default: raddr_w = ki_w;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rs_q <= smem[raddr_w];
    rc_q <= cmem[raddr_w];
    rp_q <= pmem[raddr_w];
  end

  // Tick capture and the scan over the strike table.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && action_i == ACT_TICK) begin
      price_q <= underlying_price_i;
      time_q  <= tick_time_i;
      ol_q    <= l_q;
      om_q    <= m_q;
      ou_q    <= u_q;
    end
    if (cmd_i.scan_clr) begin
      k_q <= '0;
    end else if (cmd_i.scan_step) begin
      k_q    <= k_q + CW'(1);
      prev_q <= rs_q;
    end
  end

  // Selected set and hysteresis triggers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q  <= '0;
      m_q  <= '0;
      u_q  <= '0;
      ut_q <= '0;
      lt_q <= '0;
    end else begin
      if (cmd_i.commit_up) begin
        l_q <= ki_w - AW'(1);
        m_q <= ki_w;
        u_q <= ki_w + AW'(1);
      end else if (cmd_i.commit_dn) begin
        l_q <= ki_w - AW'(2);
        m_q <= ki_w - AW'(1);
        u_q <= ki_w;
      end
      if (cmd_i.trig_ld) begin
        ut_q <= su_q - ((su_q - sm_q) >> 2);
        lt_q <= sl_q + ((sm_q - sl_q) >> 2);
      end
    end
  end

  // Capture of the fetched strikes and volatilities.
  always_ff @(posedge clk_i) begin
    case (cmd_i.cap)
      CAP_L: begin
        sl_q <= rs_q;
        cl_q <= rc_q;
        pl_q <= rp_q;
      end
      CAP_M: begin
        sm_q <= rs_q;
        cm_q <= rc_q;
        pm_q <= rp_q;
      end
      CAP_U: begin
        su_q <= rs_q;
        cu_q <= rc_q;
        pu_q <= rp_q;
      end
      default: begin
      end
    endcase
  end

  // Interpolation operands: the pair on the price's side of the middle strike.
  assign above_w = price_q > sm_q;
  assign eq_w    = price_q == sm_q;
  assign sa_w    = above_w ? sm_q : sl_q;
  assign sb_w    = above_w ? su_q : sm_q;
  assign vac_w   = (eq_w || above_w) ? cm_q : cl_q;
  assign vbc_w   = above_w ? cu_q : cm_q;
  assign vap_w   = (eq_w || above_w) ? pm_q : pl_q;
  assign vbp_w   = above_w ? pu_q : pm_q;
  assign den_w   = {1'b0, sb_w} - {1'b0, sa_w};
  assign dp_w    = {1'b0, price_q} - {1'b0, sa_w};
  assign dvc_w   = {1'b0, vbc_w} - {1'b0, vac_w};
  assign dvp_w   = {1'b0, vbp_w} - {1'b0, vap_w};
  assign den_n_w = (PRICE_W + 1)'(0) - den_w;
  assign dp_n_w  = (PRICE_W + 1)'(0) - dp_w;
  assign dvc_n_w = (VOL_W + 1)'(0) - dvc_w;
  assign dvp_n_w = (VOL_W + 1)'(0) - dvp_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.int_a) begin
      den_mag_q <= den_w[PRICE_W] ? den_n_w[PRICE_W-1:0] : den_w[PRICE_W-1:0];
      dp_mag_q  <= dp_w[PRICE_W] ? dp_n_w[PRICE_W-1:0] : dp_w[PRICE_W-1:0];
      dvc_mag_q <= dvc_w[VOL_W] ? dvc_n_w[VOL_W-1:0] : dvc_w[VOL_W-1:0];
      dvp_mag_q <= dvp_w[VOL_W] ? dvp_n_w[VOL_W-1:0] : dvp_w[VOL_W-1:0];
      negc_q    <= dvc_w[VOL_W] ^ dp_w[PRICE_W] ^ den_w[PRICE_W];
      negp_q    <= dvp_w[VOL_W] ^ dp_w[PRICE_W] ^ den_w[PRICE_W];
      direct_q  <= eq_w || (den_w == '0);
      vac_q     <= vac_w;
      vap_q     <= vap_w;
    end
    if (cmd_i.int_b) begin
      prodc_q <= dvc_mag_q * dp_mag_q;
      prodp_q <= dvp_mag_q * dp_mag_q;
    end
    if (cmd_i.sat) begin
      cv_q <= apply_quot(vac_q, qc_w, negc_q, direct_q);
      pv_q <= apply_quot(vap_q, qp_w, negp_q, direct_q);
    end
  end

  // Serial dividers, one per volatility, sharing the strike gap as divisor.
  aswi_div u_div_call (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (prodc_q),
    .divisor_i  (den_mag_q),
    .quotient_o (qc_w),
    .busy_o     (busy_c_w)
  );

  aswi_div u_div_put (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (prodp_q),
    .divisor_i  (den_mag_q),
    .quotient_o (qp_w),
    .busy_o     (busy_p_w)
  );

  // Status toward the controller.
  always_comb begin
    stat_o.clr_last   = clr_q == AW'(MAX_STRIKES - 1);
    stat_o.outside    = (price_q > ut_q) || (price_q < lt_q);
    stat_o.k_end      = k_q >= n_w;
    stat_o.hit        = rs_q >= price_q;
    stat_o.k_zero     = k_q == '0;
    stat_o.upper_side = {price_q, 1'b0} >= ({1'b0, rs_q} + {1'b0, prev_q});
    stat_o.upper_ok   = ({1'b0, k_q} + (CW + 1)'(1)) < {1'b0, n_w};
    stat_o.lower_ok   = k_q != CW'(1);
    stat_o.direct     = direct_q;
    stat_o.div_busy   = busy_c_w || busy_p_w;
  end

  // Result word payload.
  always_comb begin
    event_kind_o    = EV_START;
    watched_entry_o = '0;
    out_time_o      = '0;
    out_price_o     = '0;
    call_vol_out_o  = '0;
    put_vol_out_o   = '0;
    case (cmd_i.emit)
      EM_START_U: watched_entry_o = ENTRY_W'(u_q);
      EM_START_M: watched_entry_o = ENTRY_W'(m_q);
      EM_START_L: watched_entry_o = ENTRY_W'(l_q);
      EM_STOP_U: begin
        event_kind_o    = EV_STOP;
        watched_entry_o = ENTRY_W'(ou_q);
      end
      EM_STOP_M: begin
        event_kind_o    = EV_STOP;
        watched_entry_o = ENTRY_W'(om_q);
      end
      EM_STOP_L: begin
        event_kind_o    = EV_STOP;
        watched_entry_o = ENTRY_W'(ol_q);
      end
      EM_VOL: begin
        event_kind_o   = EV_VOL;
        out_time_o     = time_q;
        out_price_o    = price_q;
        call_vol_out_o = cv_q;
        put_vol_out_o  = pv_q;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/aswi_ctrl.sv =====
module aswi_ctrl import aswi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_action_i,
  input  logic       out_ready_i,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output logic       out_last_o
);

  state_e state_q, state_d;
  emit_e  em_q, em_d;
  logic   watch_q, watch_d;
  logic   was_q, was_d;
  logic   ok_q, ok_d;
  logic   fail_w;

  // State and flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      em_q    <= EM_VOL;
      watch_q <= 1'b0;
      was_q   <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      em_q    <= em_d;
      watch_q <= watch_d;
      was_q   <= was_d;
      ok_q    <= ok_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    em_d        = em_q;
    watch_d     = watch_q;
    was_d       = was_q;
    ok_d        = ok_q;
    fail_w      = 1'b0;
    cmd_o       = '0;
    cmd_o.emit  = em_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && in_action_i == ACT_TICK) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ok_d = 1'b0;
        if (!watch_q || stat_i.outside) begin
          was_d          = watch_q;
          cmd_o.scan_clr = 1'b1;
          state_d        = ST_SCAN_RD;
        end else begin
          was_d   = 1'b0;
          state_d = ST_FETCH_L;
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd_sel = RD_SCAN;
        if (stat_i.k_end) begin
          fail_w = 1'b1;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (!stat_i.hit) begin
          cmd_o.scan_step = 1'b1;
          state_d         = ST_SCAN_RD;
        end else if (stat_i.k_zero) begin
          fail_w = 1'b1;
        end else if (stat_i.upper_side ? stat_i.upper_ok : stat_i.lower_ok) begin
          cmd_o.commit_up = stat_i.upper_side;
          cmd_o.commit_dn = !stat_i.upper_side;
          ok_d            = 1'b1;
          watch_d         = 1'b1;
          state_d         = ST_FETCH_L;
        end else begin
          fail_w = 1'b1;
        end
      end
      ST_FETCH_L: begin
        cmd_o.rd_sel = RD_L;
        state_d      = ST_FETCH_M;
      end
      ST_FETCH_M: begin
        cmd_o.rd_sel = RD_M;
        cmd_o.cap    = CAP_L;
        state_d      = ST_FETCH_U;
      end
      ST_FETCH_U: begin
        cmd_o.rd_sel = RD_U;
        cmd_o.cap    = CAP_M;
        state_d      = ST_FETCH_END;
      end
      ST_FETCH_END: begin
        cmd_o.cap = CAP_U;
        state_d   = ST_INT_A;
      end
      ST_INT_A: begin
        cmd_o.int_a   = 1'b1;
        cmd_o.trig_ld = ok_q;
        state_d       = ST_INT_B;
      end
      ST_INT_B: begin
        cmd_o.int_b = 1'b1;
        state_d     = stat_i.direct ? ST_SAT : ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat_i.div_busy) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        em_d      = ok_q ? EM_START_U : (was_q ? EM_STOP_U : EM_VOL);
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = (em_q == EM_VOL) || (em_q == EM_STOP_L && !watch_q);
        if (out_ready_i) begin
          case (em_q)
            EM_START_U: em_d = EM_START_M;
            EM_START_M: em_d = EM_START_L;
            EM_START_L: em_d = was_q ? EM_STOP_U : EM_VOL;
            EM_STOP_U:  em_d = EM_STOP_M;
            EM_STOP_M:  em_d = EM_STOP_L;
            EM_STOP_L:  em_d = EM_VOL;
            default:    em_d = EM_VOL;
          endcase
          if (out_last_o) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A failed reselection drops the watch and reports the old set if there was one.
    if (fail_w) begin
      watch_d = 1'b0;
      if (was_q) begin
        em_d    = EM_STOP_U;
        state_d = ST_EMIT;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

endmodule

// ===== design/atm_strike_watch_interpolator.sv =====
// Loads and volatility updates are taken while idle and give no result word.
// A tick searches the strike table entry by entry, fetches the selected set and
// interpolates through the 48-step serial divider; a tick inside the trigger band skips
// the scan, and a zero gap or a price on the middle strike skips the divider.
// Reset is asynchronous, active low; a clearing pass then zeroes the volatility tables.
module atm_strike_watch_interpolator import aswi_pkg::*; #(
  parameter int MAX_STRIKES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  aswi_in_if.sink    in_i,
  aswi_out_if.source out_o,
  aswi_cfg_if.sink   cfg_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_i.ready = 1'b1;

  // Sequencer for scan, fetch, interpolation and result words.
  aswi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_o.last)
  );

  // Tables, selection registers and arithmetic.
  aswi_dp #(
    .MAX_STRIKES (MAX_STRIKES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .action_i           (in_i.action),
    .entry_index_i      (in_i.entry_index),
    .strike_price_i     (in_i.strike_price),
    .call_vol_in_i      (in_i.call_vol_in),
    .put_vol_in_i       (in_i.put_vol_in),
    .underlying_price_i (in_i.underlying_price),
    .tick_time_i        (in_i.tick_time),
    .cfg_valid_i        (cfg_i.valid),
    .strike_count_i     (cfg_i.strike_count),
    .event_kind_o       (out_o.event_kind),
    .watched_entry_o    (out_o.watched_entry),
    .out_time_o         (out_o.out_time),
    .out_price_o        (out_o.out_price),
    .call_vol_out_o     (out_o.call_vol_out),
    .put_vol_out_o      (out_o.put_vol_out)
  );

endmodule

// ===== design/aswi_checker.sv =====
`include "atm_strike_watch_interpolator_macros.svh"

module aswi_checker import aswi_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic       out_last
);

  // A waiting result word stays offered.
  `ASWI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // An accepted tick closes the input until its work is done.
  `ASWI_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && in_action == ACT_TICK, !in_ready)

  // No new word is taken while results are pending.
  `ASWI_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)

  // The volatility word always closes a tick.
  `ASWI_ASSERT_SAME(a_vol_last, out_valid && out_kind == EV_VOL, out_last)

endmodule

bind atm_strike_watch_interpolator aswi_checker u_aswi_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_action (in_i.action),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.event_kind),
  .out_last  (out_o.last)
);

// ===== tb/tb_if.sv =====
// Testbench-side copies of the channel interfaces are not needed; the design
// interfaces are instantiated directly. This file holds the word types shared by
// the driver tasks and the scoreboard.
package tb_words_pkg;
  import aswi_pkg::*;

  // One input word.
  typedef struct {
    logic [1:0]         action;
    logic [ENTRY_W-1:0] entry_index;
    logic [PRICE_W-1:0] strike_price;
    logic [VOL_W-1:0]   call_vol_in;
    logic [VOL_W-1:0]   put_vol_in;
    logic [PRICE_W-1:0] underlying_price;
    logic [TIME_W-1:0]  tick_time;
  } in_word_t;

  // One result word.
  typedef struct {
    logic [1:0]         event_kind;
    logic [ENTRY_W-1:0] watched_entry;
    logic [TIME_W-1:0]  out_time;
    logic [PRICE_W-1:0] out_price;
    logic [VOL_W-1:0]   call_vol_out;
    logic [VOL_W-1:0]   put_vol_out;
    logic               last;
  } out_word_t;
endpackage

// ===== tb/tb_top.sv =====
module tb_top;
  import aswi_pkg::*;
  import tb_words_pkg::*;

  localparam int NSTRIKE = 64;
  localparam longint CYCLE_LIMIT = 400000;

  // Watch-state predictor and queue of expected result words.
  class strike_watch_board;
    bit [31:0] strikes[NSTRIKE];
    bit [15:0] call_vols[NSTRIKE];
    bit [15:0] put_vols[NSTRIKE];
    bit        watching;
    int        lo_ix, mid_ix, up_ix;
    bit [31:0] up_trig, lo_trig;
    int        count;
    out_word_t pending[$];
    int        errors;

    function new();
      foreach (call_vols[i]) begin
        strikes[i] = 0;
        call_vols[i] = 0;
        put_vols[i] = 0;
      end
      watching = 0;
      lo_ix = 0; mid_ix = 0; up_ix = 0;
      up_trig = 0; lo_trig = 0;
      count = 0;
      errors = 0;
    endfunction

    function void set_count(int c);
      count = (c > NSTRIKE) ? NSTRIKE : c;
    endfunction

    function bit pick_set(bit [31:0] price);
      int i;
      bit [32:0] twice, sum;
      int lw, md, up;
      i = 0;
      while (i < count && strikes[i] < price) i++;
      if (i >= count || i == 0) return 0;
      twice = {price, 1'b0};
      sum = {1'b0, strikes[i]} + {1'b0, strikes[i-1]};
      if (twice >= sum) begin
        if (i + 1 >= count) return 0;
        lw = i - 1; md = i; up = i + 1;
      end else begin
        if (i - 1 == 0) return 0;
        lw = i - 2; md = i - 1; up = i;
      end
      lo_ix = lw; mid_ix = md; up_ix = up;
      up_trig = strikes[up] - ((strikes[up] - strikes[md]) >> 2);
      lo_trig = strikes[lw] + ((strikes[md] - strikes[lw]) >> 2);
      return 1;
    endfunction

    function bit [15:0] blend(bit [15:0] va, bit [15:0] vb, bit [31:0] sa, bit [31:0] sb,
                              bit [31:0] p);
      longint gap, v;
      gap = longint'(sb) - longint'(sa);
      v = va;
      if (gap != 0)
        v += (longint'(vb) - longint'(va)) * (longint'(p) - longint'(sa)) / gap;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
    endfunction

    function void push(event_e k, int ent, bit [31:0] t, bit [31:0] p,
                       bit [15:0] cv, bit [15:0] pv);
      out_word_t w;
      w.event_kind = k;
      w.watched_entry = ent[5:0];
      w.out_time = t;
      w.out_price = p;
      w.call_vol_out = cv;
      w.put_vol_out = pv;
      w.last = 0;
      pending.push_back(w);
    endfunction

    // Note an accepted input word and queue what it causes.
    function void note_input(in_word_t w);
      int n0, ou, om, ol;
      bit was;
      bit [31:0] p, sm;
      bit [15:0] cv, pv;
      n0 = pending.size();
      p = w.underlying_price;
      if (w.action == ACT_LOAD) begin
        strikes[w.entry_index] = w.strike_price;
        return;
      end
      if (w.action == ACT_UPDATE) begin
        call_vols[w.entry_index] = w.call_vol_in;
        put_vols[w.entry_index] = w.put_vol_in;
        return;
      end
      if (w.action != ACT_TICK) return;
      if (!watching || p > up_trig || p < lo_trig) begin
        was = watching;
        ou = up_ix; om = mid_ix; ol = lo_ix;
        watching = pick_set(p);
        if (watching) begin
          push(EV_START, up_ix, 0, 0, 0, 0);
          push(EV_START, mid_ix, 0, 0, 0, 0);
          push(EV_START, lo_ix, 0, 0, 0, 0);
        end
        if (was) begin
          push(EV_STOP, ou, 0, 0, 0, 0);
          push(EV_STOP, om, 0, 0, 0, 0);
          push(EV_STOP, ol, 0, 0, 0, 0);
        end
      end
      if (watching) begin
        sm = strikes[mid_ix];
        if (p == sm) begin
          cv = call_vols[mid_ix];
          pv = put_vols[mid_ix];
        end else if (p > sm) begin
          cv = blend(call_vols[mid_ix], call_vols[up_ix], sm, strikes[up_ix], p);
          pv = blend(put_vols[mid_ix], put_vols[up_ix], sm, strikes[up_ix], p);
        end else begin
          cv = blend(call_vols[lo_ix], call_vols[mid_ix], strikes[lo_ix], sm, p);
          pv = blend(put_vols[lo_ix], put_vols[mid_ix], strikes[lo_ix], sm, p);
        end
        push(EV_VOL, 0, w.tick_time, p, cv, pv);
      end
      if (pending.size() > n0) pending[pending.size()-1].last = 1;
    endfunction

    // Compare one result word against the oldest expectation.
    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word kind %0d entry %0d", $time,
                 got.event_kind, got.watched_entry);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.event_kind !== exp_w.event_kind) begin
        $display("%0t: event_kind expected %0d actual %0d", $time, exp_w.event_kind,
                 got.event_kind);
        errors++;
      end
      if (got.watched_entry !== exp_w.watched_entry) begin
        $display("%0t: watched_entry expected %0d actual %0d", $time,
                 exp_w.watched_entry, got.watched_entry);
        errors++;
      end
      if (got.out_time !== exp_w.out_time) begin
        $display("%0t: out_time expected %h actual %h", $time, exp_w.out_time,
                 got.out_time);
        errors++;
      end
      if (got.out_price !== exp_w.out_price) begin
        $display("%0t: out_price expected %h actual %h", $time, exp_w.out_price,
                 got.out_price);
        errors++;
      end
      if (got.call_vol_out !== exp_w.call_vol_out) begin
        $display("%0t: call_vol_out expected %h actual %h", $time, exp_w.call_vol_out,
                 got.call_vol_out);
        errors++;
      end
      if (got.put_vol_out !== exp_w.put_vol_out) begin
        $display("%0t: put_vol_out expected %h actual %h", $time, exp_w.put_vol_out,
                 got.put_vol_out);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last expected %0d actual %0d", $time, exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  longint cycles = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 68;
  bit [31:0] ladder[NSTRIKE];
  int ladder_n;
  strike_watch_board board;

  aswi_in_if  in_ch ();
  aswi_out_if out_ch ();
  aswi_cfg_if cfg_ch ();

  atm_strike_watch_interpolator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("atm_strike_watch_interpolator test failed");
      $finish;
    end
  end

  // Result side: random stalls and checking of each accepted word.
  always @(posedge clk_i) begin
    out_word_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.event_kind = out_ch.event_kind;
      got.watched_entry = out_ch.watched_entry;
      got.out_time = out_ch.out_time;
      got.out_price = out_ch.out_price;
      got.call_vol_out = out_ch.call_vol_out;
      got.put_vol_out = out_ch.put_vol_out;
      got.last = out_ch.last;
      board.check_result(got);
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one input word, idling at random before it. Valid stays up after the
  // accepting edge so that a following word can go back to back; whoever stops
  // sending drops it.
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.action <= w.action;
    in_ch.entry_index <= w.entry_index;
    in_ch.strike_price <= w.strike_price;
    in_ch.call_vol_in <= w.call_vol_in;
    in_ch.put_vol_in <= w.put_vol_in;
    in_ch.underlying_price <= w.underlying_price;
    in_ch.tick_time <= w.tick_time;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_input(w);
  endtask

  task automatic send_load(int ent, bit [31:0] s);
    in_word_t w;
    w.action = ACT_LOAD; w.entry_index = ENTRY_W'(ent); w.strike_price = s;
    w.call_vol_in = VOL_W'($urandom); w.put_vol_in = VOL_W'($urandom);
    w.underlying_price = $urandom; w.tick_time = $urandom;
    send_word(w);
  endtask

  task automatic send_vols(int ent, bit [15:0] cv, bit [15:0] pv);
    in_word_t w;
    w.action = ACT_UPDATE; w.entry_index = ENTRY_W'(ent); w.call_vol_in = cv;
    w.put_vol_in = pv;
    w.strike_price = $urandom; w.underlying_price = $urandom; w.tick_time = $urandom;
    send_word(w);
  endtask

  task automatic send_tick(bit [31:0] p);
    in_word_t w;
    w.action = ACT_TICK; w.underlying_price = p; w.tick_time = $urandom;
    w.entry_index = ENTRY_W'($urandom); w.strike_price = $urandom;
    w.call_vol_in = VOL_W'($urandom); w.put_vol_in = VOL_W'($urandom);
    send_word(w);
  endtask

  // Stop sending, wait until every expected word has arrived, then let the block settle.
  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Write the strike count once the block has gone idle.
  task automatic write_count(int c);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.strike_count <= COUNT_W'(c);
    do @(posedge clk_i); while (!cfg_ch.ready);
    board.set_count(c);
    cfg_ch.valid <= 0;
  endtask

  // Load a non-decreasing ladder of n strikes with random gaps, and volatilities on some.
  task automatic load_ladder(int n, bit [31:0] base, int max_gap);
    bit [31:0] s;
    s = base;
    for (int i = 0; i < n; i++) begin
      ladder[i] = s;
      send_load(i, s);
      if (i % 4 == 0) send_vols(i, VOL_W'($urandom), VOL_W'($urandom));
      s = s + $urandom_range(max_gap, 0);
    end
    ladder_n = n;
  endtask

  // A price near the loaded ladder, mostly inside its span.
  function automatic bit [31:0] near_price();
    int k;
    k = $urandom_range(ladder_n - 1);
    case ($urandom_range(9))
      0: return $urandom;
      1: return ladder[k];
      default: return ladder[k] + $urandom_range(32'h30000) - 32'h18000;
    endcase
  endfunction

  task automatic random_phase(int items);
    for (int j = 0; j < items; j++) begin
      case ($urandom_range(19))
        0: send_vols($urandom_range(ladder_n - 1), VOL_W'($urandom), VOL_W'($urandom));
        1: begin
          in_word_t w;
          w.action = ACT_NONE; w.entry_index = ENTRY_W'($urandom);
          w.strike_price = $urandom;
          w.call_vol_in = VOL_W'($urandom); w.put_vol_in = VOL_W'($urandom);
          w.underlying_price = $urandom; w.tick_time = $urandom;
          send_word(w);
        end
        default: send_tick(near_price());
      endcase
    end
  endtask

  initial begin
    board = new();
    in_ch.valid = 0; in_ch.action = ACT_LOAD; in_ch.entry_index = 0;
    in_ch.strike_price = 0; in_ch.call_vol_in = 0; in_ch.put_vol_in = 0;
    in_ch.underlying_price = 0; in_ch.tick_time = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.strike_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: a tick with no strikes, then a small ladder with edge cases.
    send_tick(32'h0001_0000);
    write_count(4);
    send_load(0, 32'h0000_0000);
    send_load(1, 32'h0001_0000);
    send_load(2, 32'h0001_0000);
    send_load(3, 32'hFFFF_FFFF);
    send_vols(0, 16'h0000, 16'hFFFF);
    send_vols(1, 16'hFFFF, 16'h0000);
    send_vols(2, 16'h1234, 16'h8000);
    send_vols(3, 16'hFFFF, 16'hFFFF);
    send_vols(63, 16'h5555, 16'hAAAA);
    send_tick(32'h0000_8000);
    send_tick(32'h0001_0000);
    send_tick(32'h0001_0001);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'h0000_0000);
    send_tick(32'h8000_0000);
    send_tick(32'h7FFF_FFFF);
    send_load(63, 32'hFFFF_FFFF);
    drain();
    // Count change while watching; stored set stays until the next reselection.
    write_count(3);
    send_tick(32'h0001_0000);
    send_tick(32'hF000_0000);
    drain();

    // Out-of-order strikes exercise saturation.
    write_count(3);
    send_load(0, 32'h0010_0000);
    send_load(1, 32'h0002_0000);
    send_load(2, 32'h0020_0000);
    send_tick(32'h0001_0000);
    send_tick(32'h0018_0000);
    drain();

    // Random phases over several counts.
    write_count(64);
    load_ladder(64, 32'h0010_0000, 32'h0004_0000);
    random_phase(15);
    drain();
    send_idle_pct = 68; recv_idle_pct = 23;
    write_count(127);
    random_phase(15);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_count(8);
    load_ladder(8, $urandom_range(32'h8000_0000), 32'h0002_0000);
    random_phase(15);
    drain();
    write_count(0);
    send_tick(32'h0001_0000);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("atm_strike_watch_interpolator test passed");
    end else begin
      $display("atm_strike_watch_interpolator test failed");
    end
    $finish;
  end
endmodule
